// ----- sv/ach_pkg.sv -----
package ach_pkg;

  localparam int CAPACITY = 1024;
  localparam int AW       = $clog2(CAPACITY);  // bucket and table address width
  localparam int CW       = AW + 1;            // counts that reach CAPACITY
  localparam int RW       = 11;                // configuration register width
  localparam int KW       = 64;
  localparam int HW       = 32;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 5;

  localparam logic [HW-1:0] CRC_POLY = 32'h82F63B78;
  localparam logic [CNT_W-1:0] CRC_LAST = CNT_W'(KW / 8 - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(HW - 1);

  localparam logic [IDX_W-1:0] REG_ANCHOR_COUNT    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_INITIAL_WORKING = IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_ADD    = 2'd2,
    KIND_INIT   = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_BOOT, S_BOOT_SWEEP, S_IDLE, S_DISPATCH,
    S_CRC1, S_DIVM, S_DIV1, S_RDB, S_CHKB,
    S_CRC2, S_DIVV, S_DIV2, S_RDH, S_TR,
    S_RMCHK, S_ADDWR, S_SWEEP, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_CRC, CMD_DIV_M, CMD_DIV_V, CMD_DIV,
    CMD_RD_B, CMD_DONE_B, CMD_REHASH, CMD_RD_H, CMD_TR_NEXT, CMD_B_FROM_H,
    CMD_RM_RD, CMD_RM_SETUP, CMD_RM_WR, CMD_REJECT, CMD_ADD_RD, CMD_ADD_WR,
    CMD_INIT_START, CMD_SWEEP, CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  crc_last;
    logic  div_last;
    logic  sweep_last;
    logic  anch_zero;
    logic  tr_more;
    logic  rm_reject;
    logic  stack_empty;
    logic  out_free;
  } status_t;

  // eight reflected CRC32C bit steps, no inversion
  function automatic logic [HW-1:0] crc_byte(input logic [HW-1:0] c_in,
                                             input logic [7:0] d);
    logic [HW-1:0] c;
    logic          fb;
    c = c_in;
    for (int j = 0; j < 8; j++) begin
      fb = c[0] ^ d[j];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

endpackage

// ----- sv/ach_req_if.sv -----
interface ach_req_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [ach_pkg::KW-1:0] key_first;
  logic [ach_pkg::KW-1:0] key_second;
  logic [ach_pkg::AW-1:0] target_bucket;

  modport source (output valid, kind, key_first, key_second, target_bucket, input ready);
  modport sink   (input valid, kind, key_first, key_second, target_bucket, output ready);
endinterface

// ----- sv/ach_rsp_if.sv -----
interface ach_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [ach_pkg::AW-1:0] bucket;
  logic                   status;

  modport source (output valid, bucket, status, input ready);
  modport sink   (input valid, bucket, status, output ready);
endinterface

// ----- sv/ach_cfg_if.sv -----
interface ach_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ach_pkg::IDX_W-1:0] index;
  logic [ach_pkg::RW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ach_ram.sv -----
module ach_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ach_ctrl.sv -----
module ach_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  ach_pkg::status_t st,
  output ach_pkg::cmd_t    cmd
);

  ach_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ach_pkg::S_BOOT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = ach_pkg::CMD_NONE;
    req_ready  = 1'b0;
    case (state)
      ach_pkg::S_BOOT: begin
        cmd        = ach_pkg::CMD_INIT_START;
        state_next = ach_pkg::S_BOOT_SWEEP;
      end
      ach_pkg::S_BOOT_SWEEP: begin
        cmd = ach_pkg::CMD_SWEEP;
        if (st.sweep_last) state_next = ach_pkg::S_IDLE;
      end
      ach_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd        = ach_pkg::CMD_ACCEPT;
          state_next = ach_pkg::S_DISPATCH;
        end
      end
      ach_pkg::S_DISPATCH: begin
        case (st.kind)
          ach_pkg::KIND_LOOKUP: state_next = ach_pkg::S_CRC1;
          ach_pkg::KIND_REMOVE: begin
            cmd        = ach_pkg::CMD_RM_RD;
            state_next = ach_pkg::S_RMCHK;
          end
          ach_pkg::KIND_ADD: begin
            if (st.stack_empty) begin
              cmd        = ach_pkg::CMD_REJECT;
              state_next = ach_pkg::S_DONE;
            end else begin
              cmd        = ach_pkg::CMD_ADD_RD;
              state_next = ach_pkg::S_ADDWR;
            end
          end
          default: begin
            cmd        = ach_pkg::CMD_INIT_START;
            state_next = ach_pkg::S_SWEEP;
          end
        endcase
      end
      ach_pkg::S_CRC1: begin
        cmd = ach_pkg::CMD_CRC;
        if (st.crc_last) state_next = ach_pkg::S_DIVM;
      end
      ach_pkg::S_DIVM: begin
        cmd        = ach_pkg::CMD_DIV_M;
        state_next = ach_pkg::S_DIV1;
      end
      ach_pkg::S_DIV1: begin
        cmd = ach_pkg::CMD_DIV;
        if (st.div_last) state_next = ach_pkg::S_RDB;
      end
      ach_pkg::S_RDB: begin
        cmd        = ach_pkg::CMD_RD_B;
        state_next = ach_pkg::S_CHKB;
      end
      ach_pkg::S_CHKB: begin
        if (st.anch_zero) begin
          cmd        = ach_pkg::CMD_DONE_B;
          state_next = ach_pkg::S_DONE;
        end else begin
          cmd        = ach_pkg::CMD_REHASH;
          state_next = ach_pkg::S_CRC2;
        end
      end
      ach_pkg::S_CRC2: begin
        cmd = ach_pkg::CMD_CRC;
        if (st.crc_last) state_next = ach_pkg::S_DIVV;
      end
      ach_pkg::S_DIVV: begin
        cmd        = ach_pkg::CMD_DIV_V;
        state_next = ach_pkg::S_DIV2;
      end
      ach_pkg::S_DIV2: begin
        cmd = ach_pkg::CMD_DIV;
        if (st.div_last) state_next = ach_pkg::S_RDH;
      end
      ach_pkg::S_RDH: begin
        cmd        = ach_pkg::CMD_RD_H;
        state_next = ach_pkg::S_TR;
      end
      ach_pkg::S_TR: begin
        if (st.tr_more) begin
          cmd = ach_pkg::CMD_TR_NEXT;
        end else if (st.kind == ach_pkg::KIND_LOOKUP) begin
          cmd        = ach_pkg::CMD_B_FROM_H;
          state_next = ach_pkg::S_CHKB;
        end else begin
          cmd        = ach_pkg::CMD_RM_WR;
          state_next = ach_pkg::S_DONE;
        end
      end
      ach_pkg::S_RMCHK: begin
        if (st.rm_reject) begin
          cmd        = ach_pkg::CMD_REJECT;
          state_next = ach_pkg::S_DONE;
        end else begin
          cmd        = ach_pkg::CMD_RM_SETUP;
          state_next = ach_pkg::S_TR;
        end
      end
      ach_pkg::S_ADDWR: begin
        cmd        = ach_pkg::CMD_ADD_WR;
        state_next = ach_pkg::S_DONE;
      end
      ach_pkg::S_SWEEP: begin
        cmd = ach_pkg::CMD_SWEEP;
        if (st.sweep_last) state_next = ach_pkg::S_DONE;
      end
      ach_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd        = ach_pkg::CMD_OUT_LOAD;
          state_next = ach_pkg::S_IDLE;
        end
      end
      default: state_next = ach_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- sv/ach_datapath.sv -----
module ach_datapath (
  input  logic              clk,
  input  logic              rst,
  ach_req_if.sink           req,
  ach_rsp_if.source         rsp,
  ach_cfg_if.sink           cfg,
  input  ach_pkg::cmd_t     cmd,
  output ach_pkg::status_t  st
);

  localparam logic [ach_pkg::CW-1:0] CAP = ach_pkg::CW'(ach_pkg::CAPACITY);

  logic [ach_pkg::RW-1:0]    reg_anchor, reg_work;
  logic [ach_pkg::CW-1:0]    m, wc, depth;
  ach_pkg::kind_t            kind;
  logic [ach_pkg::KW-1:0]    k1, k2, data;
  logic [ach_pkg::HW-1:0]    crc, hs, dvd;
  logic [ach_pkg::CNT_W-1:0] cnt;
  logic [ach_pkg::AW-1:0]    rem, b, h, tgt;
  logic [ach_pkg::CW-1:0]    div, view;
  logic [ach_pkg::CW-1:0]    idx, sm, sw;
  logic [ach_pkg::AW-1:0]    res_bucket;
  logic                      res_status;
  logic                      out_valid;
  logic [ach_pkg::AW-1:0]    out_bucket;
  logic                      out_status;

  logic [ach_pkg::RW-1:0]    sm_c, sw_c;
  logic [ach_pkg::CW-1:0]    rem_sh;
  logic [ach_pkg::AW-1:0]    rem_next;
  logic                      in_range;

  logic                      anch_we, repl_we, stk_we;
  logic [ach_pkg::AW-1:0]    anch_waddr, repl_waddr, stk_waddr, rd_addr, stk_raddr;
  logic [ach_pkg::AW-1:0]    anch_wdata, repl_wdata, stk_wdata;
  logic [ach_pkg::AW-1:0]    anch_rd, repl_rd, stk_rd;

  ach_ram #(.WIDTH(ach_pkg::AW), .DEPTH(ach_pkg::CAPACITY)) u_anchor (
    .clk, .we(anch_we), .waddr(anch_waddr), .wdata(anch_wdata),
    .raddr(rd_addr), .rdata(anch_rd));
  ach_ram #(.WIDTH(ach_pkg::AW), .DEPTH(ach_pkg::CAPACITY)) u_repl (
    .clk, .we(repl_we), .waddr(repl_waddr), .wdata(repl_wdata),
    .raddr(rd_addr), .rdata(repl_rd));
  ach_ram #(.WIDTH(ach_pkg::AW), .DEPTH(ach_pkg::CAPACITY)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd));

  // clamped init values
  always_comb begin
    sm_c = reg_anchor;
    if (sm_c < ach_pkg::RW'(2)) sm_c = ach_pkg::RW'(2);
    if (sm_c > ach_pkg::RW'(ach_pkg::CAPACITY)) sm_c = ach_pkg::RW'(ach_pkg::CAPACITY);
    sw_c = reg_work;
    if (sw_c < ach_pkg::RW'(1)) sw_c = ach_pkg::RW'(1);
    if (sw_c > sm_c) sw_c = sm_c;
  end

  // one restoring step of hash mod divisor
  always_comb begin
    rem_sh = {rem, dvd[ach_pkg::HW-1]};
    if (rem_sh >= div) rem_next = ach_pkg::AW'(rem_sh - div);
    else               rem_next = rem_sh[ach_pkg::AW-1:0];
  end

  assign in_range = (idx >= sw) && (idx < sm);

  always_comb begin
    anch_we    = 1'b0;
    repl_we    = 1'b0;
    stk_we     = 1'b0;
    anch_waddr = idx[ach_pkg::AW-1:0];
    anch_wdata = '0;
    repl_waddr = idx[ach_pkg::AW-1:0];
    repl_wdata = idx[ach_pkg::AW-1:0];
    stk_waddr  = depth[ach_pkg::AW-1:0];
    stk_wdata  = tgt;
    rd_addr    = rem;
    stk_raddr  = ach_pkg::AW'(depth - ach_pkg::CW'(1));
    case (cmd)
      ach_pkg::CMD_SWEEP: begin
        anch_we    = 1'b1;
        anch_wdata = in_range ? idx[ach_pkg::AW-1:0] : '0;
        repl_we    = 1'b1;
        stk_we     = in_range;
        stk_waddr  = ach_pkg::AW'(sm - ach_pkg::CW'(1) - idx);
        stk_wdata  = idx[ach_pkg::AW-1:0];
      end
      ach_pkg::CMD_RM_WR: begin
        anch_we    = 1'b1;
        anch_waddr = tgt;
        anch_wdata = ach_pkg::AW'(wc - ach_pkg::CW'(1));
        repl_we    = 1'b1;
        repl_waddr = tgt;
        repl_wdata = h;
        stk_we     = 1'b1;
      end
      ach_pkg::CMD_ADD_WR: begin
        anch_we    = 1'b1;
        anch_waddr = stk_rd;
        repl_we    = 1'b1;
        repl_waddr = stk_rd;
        repl_wdata = stk_rd;
      end
      ach_pkg::CMD_RM_RD:    rd_addr = tgt;
      ach_pkg::CMD_TR_NEXT:  rd_addr = repl_rd;
      ach_pkg::CMD_B_FROM_H: rd_addr = h;
      ach_pkg::CMD_RM_SETUP: rd_addr = ach_pkg::AW'(wc - ach_pkg::CW'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_anchor <= ach_pkg::RW'(ach_pkg::CAPACITY);
      reg_work   <= ach_pkg::RW'(ach_pkg::CAPACITY);
      m          <= CAP;
      wc         <= CAP;
      depth      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == ach_pkg::REG_ANCHOR_COUNT)    reg_anchor <= cfg.data;
        if (cfg.index == ach_pkg::REG_INITIAL_WORKING) reg_work   <= cfg.data;
      end
      if (cmd == ach_pkg::CMD_OUT_LOAD) out_valid <= 1'b1;
      else if (rsp.ready)               out_valid <= 1'b0;
      case (cmd)
        ach_pkg::CMD_RM_WR: begin
          wc    <= wc - ach_pkg::CW'(1);
          depth <= depth + ach_pkg::CW'(1);
        end
        // pop and count together; the stack read already holds the old top
        ach_pkg::CMD_ADD_RD: begin
          wc    <= wc + ach_pkg::CW'(1);
          depth <= depth - ach_pkg::CW'(1);
        end
        ach_pkg::CMD_INIT_START: begin
          m     <= ach_pkg::CW'(sm_c);
          wc    <= ach_pkg::CW'(sw_c);
          depth <= ach_pkg::CW'(sm_c - sw_c);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ach_pkg::CMD_ACCEPT: begin
        kind <= ach_pkg::kind_t'(req.kind);
        k1   <= req.key_first;
        k2   <= req.key_second;
        tgt  <= req.target_bucket;
        crc  <= req.key_second[ach_pkg::HW-1:0];
        data <= req.key_first;
        cnt  <= '0;
      end
      ach_pkg::CMD_CRC: begin
        crc  <= ach_pkg::crc_byte(crc, data[7:0]);
        data <= data >> 8;
        cnt  <= cnt + ach_pkg::CNT_W'(1);
      end
      ach_pkg::CMD_DIV_M, ach_pkg::CMD_DIV_V: begin
        hs  <= crc;
        dvd <= crc;
        rem <= '0;
        cnt <= '0;
        div <= (cmd == ach_pkg::CMD_DIV_M) ? m : view;
      end
      ach_pkg::CMD_DIV: begin
        rem <= rem_next;
        dvd <= dvd << 1;
        cnt <= cnt + ach_pkg::CNT_W'(1);
      end
      ach_pkg::CMD_RD_B: b <= rem;
      ach_pkg::CMD_DONE_B: begin
        res_bucket <= b;
        res_status <= 1'b0;
      end
      ach_pkg::CMD_REHASH: begin
        view <= ach_pkg::CW'(anch_rd);
        crc  <= k2[ach_pkg::HW-1:0] + hs;
        data <= k1 - ach_pkg::KW'(hs);
        cnt  <= '0;
      end
      ach_pkg::CMD_RD_H:     h <= rem;
      ach_pkg::CMD_TR_NEXT:  h <= repl_rd;
      ach_pkg::CMD_B_FROM_H: b <= h;
      ach_pkg::CMD_RM_SETUP: begin
        view <= wc;
        h    <= ach_pkg::AW'(wc - ach_pkg::CW'(1));
      end
      ach_pkg::CMD_RM_WR: begin
        res_bucket <= '0;
        res_status <= 1'b0;
      end
      ach_pkg::CMD_REJECT: begin
        res_bucket <= '0;
        res_status <= 1'b1;
      end
      ach_pkg::CMD_ADD_WR: begin
        res_bucket <= stk_rd;
        res_status <= 1'b0;
      end
      ach_pkg::CMD_INIT_START: begin
        sm         <= ach_pkg::CW'(sm_c);
        sw         <= ach_pkg::CW'(sw_c);
        idx        <= '0;
        res_bucket <= '0;
        res_status <= 1'b0;
      end
      ach_pkg::CMD_SWEEP: idx <= idx + ach_pkg::CW'(1);
      ach_pkg::CMD_OUT_LOAD: begin
        out_bucket <= res_bucket;
        out_status <= res_status;
      end
      default: ;
    endcase
  end

  assign st.kind        = kind;
  assign st.crc_last    = (cnt == ach_pkg::CRC_LAST);
  assign st.div_last    = (cnt == ach_pkg::DIV_LAST);
  assign st.sweep_last  = (idx == CAP - ach_pkg::CW'(1));
  assign st.anch_zero   = (anch_rd == '0);
  assign st.tr_more     = (ach_pkg::CW'(anch_rd) >= view);
  assign st.rm_reject   = (ach_pkg::CW'(tgt) >= m) || (anch_rd != '0) ||
                          (wc <= ach_pkg::CW'(1)) || (depth >= CAP);
  assign st.stack_empty = (depth == '0);
  assign st.out_free    = !out_valid || rsp.ready;

  assign rsp.valid  = out_valid;
  assign rsp.bucket = out_bucket;
  assign rsp.status = out_status;
  assign cfg.ready  = 1'b1;

  // every anchor is either working or on the removed stack
  a_count_split: assert property (@(posedge clk) disable iff (rst) wc + depth == m)
    else $error("working plus removed differs from anchor count");
  a_one_working: assert property (@(posedge clk) disable iff (rst) wc != '0)
    else $error("no working bucket left");
  a_anchor_range: assert property (@(posedge clk) disable iff (rst)
      m >= ach_pkg::CW'(2) && m <= CAP)
    else $error("anchor count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
      cmd == ach_pkg::CMD_RM_WR |-> depth < CAP)
    else $error("push onto full removed stack");

endmodule

// ----- sv/anchor_consistent_hash_top.sv -----
// Consistent-hash bucket selector with anchor and replacement tables.
// Channels: req carries kind (lookup, remove, add, init), a 128-bit key and
// a target bucket; rsp returns one transaction per request, bucket and status
// (status 1 marks a rejected remove or add). cfg writes anchor_count (index 0)
// and initial_working (index 1); they take effect at the next init.
// One request is worked on at a time; req.ready is high only when idle, and
// a new request is taken in the cycle after the previous result is loaded.
// A lookup folds eight key bytes into a CRC at a byte a cycle, then takes the
// hash modulo the anchor count by bit-serial division. If that bucket is not
// working, each rehash round repeats the CRC and the modulo and then follows
// the replacement chain hop by hop. Remove and add each update the tables.
// Init rewrites all 1024 table rows at one row a cycle.
// After reset the block runs a table pass with the reset register values
// before it raises req.ready; no response comes from it.
// The response sits in an output register: a new request is taken while it
// waits, and a finished result waits in its state until rsp.ready frees it.
module anchor_consistent_hash_top (
  input logic        clk,
  input logic        rst,
  ach_req_if.sink    req,
  ach_rsp_if.source  rsp,
  ach_cfg_if.sink    cfg
);

  ach_pkg::cmd_t    cmd;
  ach_pkg::status_t st;
  logic             req_ready;

  assign req.ready = req_ready;

  ach_ctrl u_ctrl (
    .clk,
    .rst,
    .req_valid (req.valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ach_datapath u_datapath (
    .clk,
    .rst,
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .st  (st)
  );

endmodule
